// ----- hdl/sobel_pkg.sv -----
`default_nettype none
package sobel_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel_in;

    typedef struct packed {
        logic [15:0] out_row;
        logic [9:0]  out_col;
        logic [7:0]  edge_red;
        logic [7:0]  edge_green;
        logic [7:0]  edge_blue;
        logic        last_of_run;
    } t_result;

    // configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;

    localparam logic [7:0]  PIX_MAX   = 8'd255;
    localparam logic [20:0] MAG_LIMIT = 21'd65280;   // 255*255 + 255

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PICK,
        ST_SQUARE,
        ST_ROOT,
        ST_FINISH,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic update;   // line stores and window take the new pixel
        logic pick;     // choose next pending output, form gradients
        logic square;   // form gx^2 + gy^2
        logic root;     // one bit of the square root
        logic finish;   // round, clamp and load the output register
    } t_cmd;

    typedef struct packed {
        logic none_pending;
        logic root_last;
    } t_sts;

endpackage
`default_nettype wire

// ----- hdl/sobel_ram.sv -----
`default_nettype none
module sobel_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- hdl/sobel_ctrl.sv -----
`default_nettype none
module sobel_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire sobel_pkg::t_sts  i_sts,
    output sobel_pkg::t_cmd       o_cmd
);

    sobel_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sobel_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            sobel_pkg::ST_IDLE: begin
                // hold off the input channel while in reset
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    n_state = sobel_pkg::ST_READ;
                end
            end
            sobel_pkg::ST_READ: begin
                o_cmd.update = 1'b1;
                n_state      = sobel_pkg::ST_PICK;
            end
            sobel_pkg::ST_PICK: begin
                if (i_sts.none_pending) begin
                    n_state = sobel_pkg::ST_IDLE;
                end else begin
                    o_cmd.pick = 1'b1;
                    n_state    = sobel_pkg::ST_SQUARE;
                end
            end
            sobel_pkg::ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = sobel_pkg::ST_ROOT;
            end
            sobel_pkg::ST_ROOT: begin
                o_cmd.root = 1'b1;
                if (i_sts.root_last) begin
                    n_state = sobel_pkg::ST_FINISH;
                end
            end
            sobel_pkg::ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = sobel_pkg::ST_SEND;
            end
            sobel_pkg::ST_SEND: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = sobel_pkg::ST_PICK;
                end
            end
            default: begin
                n_state = sobel_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/sobel_dp.sv -----
`default_nettype none
module sobel_dp #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_idx,
    input  wire logic [15:0]          i_cfg_data,
    input  wire logic                 i_in_accept,
    input  wire sobel_pkg::t_pixel_in i_in_data,
    input  wire sobel_pkg::t_cmd      i_cmd,
    output sobel_pkg::t_sts           o_sts,
    output sobel_pkg::t_result        o_out_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > 11) ? CW + 1 : 11;

    logic [10:0]   r_frame_w;
    logic [15:0]   r_frame_h;
    logic [15:0]   r_row;
    logic [CW-1:0] r_col;
    logic [23:0]   r_pix;
    logic [23:0]   r_win [9];
    logic [3:0]    r_mask;
    logic [15:0]   r_ei;
    logic [CW-1:0] r_ej;
    logic signed [10:0] r_gx [3];
    logic signed [10:0] r_gy [3];
    logic [20:0]   r_s [3];
    logic [7:0]    r_r [3];
    logic [7:0]    r_bit;
    logic          r_last;
    logic [15:0]   r_orow;
    logic [CW-1:0] r_ocol;
    sobel_pkg::t_result r_out;

    logic [WW-1:0] w_eff, j_ext, j_next;
    logic [15:0]   h_eff;
    logic          i_ge1, i_ge2, j_ge1, j_last, i_last;
    logic [23:0]   rd_above, rd_two, top, mid;
    logic [1:0]    sel;
    logic [3:0]    rest;
    logic [23:0]   nb [9];
    logic signed [10:0] gx [3];
    logic signed [10:0] gy [3];
    logic [20:0]   sq [3];
    logic [7:0]    t_try [3];
    logic [7:0]    mag [3];

    always_comb begin
        if (r_frame_w == 11'd0) begin
            w_eff = WW'(1);
        end else if (WW'(r_frame_w) > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_frame_w);
        end
        h_eff  = (r_frame_h == 16'd0) ? 16'd1 : r_frame_h;
        j_ext  = WW'(r_col);
        j_next = j_ext + WW'(1);
        i_ge1  = (r_row != 16'd0);
        i_ge2  = (r_row >= 16'd2);
        j_ge1  = (r_col != '0);
        j_last = (j_ext == w_eff - WW'(1));
        i_last = (r_row == h_eff - 16'd1);
        top    = i_ge2 ? rd_two : 24'd0;
        mid    = i_ge1 ? rd_above : 24'd0;
    end

    sobel_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_line_above (
        .i_clk  (i_clk),
        .i_we   (i_cmd.update),
        .i_waddr(r_col),
        .i_wdata(r_pix),
        .i_raddr(r_col),
        .o_rdata(rd_above)
    );

    sobel_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_line_two_above (
        .i_clk  (i_clk),
        .i_we   (i_cmd.update),
        .i_waddr(r_col),
        .i_wdata(mid),
        .i_raddr(r_col),
        .o_rdata(rd_two)
    );

    // lowest pending output first: raster order
    always_comb begin
        int rr, cc, ch;
        int a [9];
        if (r_mask[0]) begin
            sel = 2'd0;
        end else if (r_mask[1]) begin
            sel = 2'd1;
        end else if (r_mask[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
        rest = r_mask & ~(4'b0001 << sel);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                rr = r + int'(sel[1]);
                cc = c + int'(sel[0]);
                nb[r*3+c] = (rr <= 2 && cc <= 2) ? r_win[rr*3+cc] : 24'd0;
            end
        end
        for (ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 9; k++) begin
                a[k] = int'(nb[k][(2-ch)*8 +: 8]);
            end
            gx[ch] = 11'((a[2] + 2*a[5] + a[8]) - (a[0] + 2*a[3] + a[6]));
            gy[ch] = 11'((a[6] + 2*a[7] + a[8]) - (a[0] + 2*a[1] + a[2]));
        end
    end

    always_comb begin
        logic signed [21:0] px, py, ps;
        logic [16:0] lim;
        logic [8:0]  rnd;
        for (int ch = 0; ch < 3; ch++) begin
            px = 22'(r_gx[ch]) * 22'(r_gx[ch]);
            py = 22'(r_gy[ch]) * 22'(r_gy[ch]);
            ps = px + py;
            sq[ch]    = ps[20:0];
            t_try[ch] = r_r[ch] | r_bit;
            lim = 17'(r_r[ch]) * 17'(r_r[ch]) + 17'(r_r[ch]);
            rnd = 9'(r_r[ch]) + ((r_s[ch] > 21'(lim)) ? 9'd1 : 9'd0);
            if (r_s[ch] > sobel_pkg::MAG_LIMIT || rnd > 9'(sobel_pkg::PIX_MAX)) begin
                mag[ch] = sobel_pkg::PIX_MAX;
            end else begin
                mag[ch] = rnd[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= sobel_pkg::FRAME_WIDTH_RST;
            r_frame_h <= sobel_pkg::FRAME_HEIGHT_RST;
            r_row     <= '0;
            r_col     <= '0;
            r_mask    <= '0;
            r_bit     <= '0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            if (i_cmd.update) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r*3]   <= j_ge1 ? r_win[r*3+1] : 24'd0;
                    r_win[r*3+1] <= j_ge1 ? r_win[r*3+2] : 24'd0;
                end
                r_win[2] <= top;
                r_win[5] <= mid;
                r_win[8] <= r_pix;
                r_mask   <= {i_last & j_last, i_last & j_ge1,
                             i_ge1 & j_last, i_ge1 & j_ge1};
                // advance raster position, wrap at end of frame
                if (j_next >= w_eff) begin
                    r_col <= '0;
                    if (17'(r_row) + 17'd1 >= 17'(h_eff)) begin
                        r_row <= '0;
                    end else begin
                        r_row <= r_row + 16'd1;
                    end
                end else begin
                    r_col <= CW'(j_next);
                end
            end
            if (i_cmd.pick) begin
                r_mask <= rest;
            end
            if (i_cmd.square) begin
                r_bit <= 8'h80;
            end
            if (i_cmd.root) begin
                r_bit <= r_bit >> 1;
            end
            // a register write restarts the frame
            if (i_cfg_we) begin
                if (i_cfg_idx == sobel_pkg::CFG_FRAME_WIDTH) begin
                    r_frame_w <= i_cfg_data[10:0];
                end else begin
                    r_frame_h <= i_cfg_data;
                end
                r_row <= '0;
                r_col <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_pix <= {i_in_data.red, i_in_data.green, i_in_data.blue};
        end
        if (i_cmd.update) begin
            r_ei <= r_row;
            r_ej <= r_col;
        end
        if (i_cmd.pick) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_gx[ch] <= gx[ch];
                r_gy[ch] <= gy[ch];
            end
            r_last <= (rest == 4'd0);
            r_orow <= sel[1] ? r_ei : r_ei - 16'd1;
            r_ocol <= sel[0] ? r_ej : r_ej - CW'(1);
        end
        for (int ch = 0; ch < 3; ch++) begin
            if (i_cmd.square) begin
                r_s[ch] <= sq[ch];
                r_r[ch] <= '0;
            end
            if (i_cmd.root && 21'(16'(t_try[ch]) * 16'(t_try[ch])) <= r_s[ch]) begin
                r_r[ch] <= t_try[ch];
            end
        end
        if (i_cmd.finish) begin
            r_out.out_row     <= r_orow;
            r_out.out_col     <= 10'(r_ocol);
            r_out.edge_red    <= mag[0];
            r_out.edge_green  <= mag[1];
            r_out.edge_blue   <= mag[2];
            r_out.last_of_run <= r_last;
        end
    end

    assign o_sts.none_pending = (r_mask == 4'd0);
    assign o_sts.root_last    = r_bit[0];
    assign o_out_data         = r_out;

endmodule
`default_nettype wire

// ----- hdl/sobel_edge_magnitude_rgb.sv -----
// Sobel edge magnitude on an RGB pixel stream.
// Input channel (i_in_valid / o_in_ready / i_in_data): one pixel per
// transaction, frames in raster order. Output channel (o_out_valid /
// i_out_ready / o_out_data): 0 to 4 results per pixel, each tagged with
// its row and column; last_of_run marks the final result of a pixel.
// Configuration: i_cfg_we writes frame width (index 0) or frame height
// (index 1) from i_cfg_data and restarts the frame at row 0, column 0.
// Steps: a pixel passes the line stores and window in order (memory
// read, update, dispatch). Each result then passes gradient, square,
// 8 square-root iterations shared by the three channels, and rounding.
// The next pixel is taken only after all results of the current one
// have been delivered.
// A stalled receiver holds the result in the output register; the block
// waits there and takes no pixel. Reset gives 640x480 at row 0, column 0
// and needs no clearing pass: line store rows are always written before
// they are read.
`default_nettype none
module sobel_edge_magnitude_rgb #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_idx,
    input  wire logic [15:0]          i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire sobel_pkg::t_pixel_in i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output sobel_pkg::t_result        o_out_data
);

    sobel_pkg::t_cmd cmd;
    sobel_pkg::t_sts sts;
    logic            in_ready;

    sobel_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sobel_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_accept(i_in_valid & in_ready),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

    assign o_in_ready = in_ready;

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH = 1024;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 40;

    class edge_scoreboard;
        bit [23:0]   line_prev [LINE_DEPTH];
        bit [23:0]   line_prev2 [LINE_DEPTH];
        bit [23:0]   win [9];
        int unsigned row_pos, col_pos;
        bit [10:0]   width_reg;
        bit [15:0]   height_reg;
        sobel_pkg::t_result pending_q [$];
        int          errors;
        int          pixels_seen;
        int          results_seen;

        function new();
            width_reg  = sobel_pkg::FRAME_WIDTH_RST;
            height_reg = sobel_pkg::FRAME_HEIGHT_RST;
        endfunction

        task report(string what, int got, int want);
            $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        function void write_reg(logic idx, bit [15:0] value);
            if (idx == sobel_pkg::CFG_FRAME_WIDTH) width_reg = value[10:0];
            else height_reg = value;
            row_pos = 0;
            col_pos = 0;
        endfunction

        function bit [7:0] grad_mag(bit [23:0] nb [9], int sh);
            int a [9];
            int gx, gy, s, r;
            for (int k = 0; k < 9; k++) a[k] = int'((nb[k] >> sh) & 24'hFF);
            gx = (a[2] + 2 * a[5] + a[8]) - (a[0] + 2 * a[3] + a[6]);
            gy = (a[6] + 2 * a[7] + a[8]) - (a[0] + 2 * a[1] + a[2]);
            s = gx * gx + gy * gy;
            if (s > 65280) return 8'd255;
            r = 0;
            while ((r + 1) * (r + 1) <= s) r++;
            if (s > r * r + r) r++;
            return (r > 255) ? 8'd255 : r[7:0];
        endfunction

        function sobel_pkg::t_result make_result(int unsigned r, int unsigned c,
                                                 int rsh, int csh);
            bit [23:0] nb [9];
            sobel_pkg::t_result res;
            for (int y = 0; y < 3; y++)
                for (int x = 0; x < 3; x++)
                    nb[y * 3 + x] = (y + rsh <= 2 && x + csh <= 2) ?
                                    win[(y + rsh) * 3 + x + csh] : 24'd0;
            res.out_row     = r[15:0];
            res.out_col     = c[9:0];
            res.edge_red    = grad_mag(nb, 16);
            res.edge_green  = grad_mag(nb, 8);
            res.edge_blue   = grad_mag(nb, 0);
            res.last_of_run = 1'b0;
            return res;
        endfunction

        function void note_pixel(sobel_pkg::t_pixel_in p);
            int unsigned w, h, i, j;
            bit [23:0]   pix, top, mid;
            sobel_pkg::t_result outs [$];
            w = (width_reg == 0) ? 1 : (width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
            h = (height_reg == 0) ? 1 : height_reg;
            i = row_pos;
            j = col_pos;
            pixels_seen++;
            if (j >= w) begin
                j = 0;
                i++;
            end
            if (i >= h) i = 0;
            pix = {p.red, p.green, p.blue};
            top = (i >= 2) ? line_prev2[j] : 24'd0;
            mid = (i >= 1) ? line_prev[j] : 24'd0;
            line_prev2[j] = mid;
            line_prev[j]  = pix;
            for (int y = 0; y < 3; y++) begin
                win[y * 3]     = (j == 0) ? 24'd0 : win[y * 3 + 1];
                win[y * 3 + 1] = (j == 0) ? 24'd0 : win[y * 3 + 2];
            end
            win[2] = top;
            win[5] = mid;
            win[8] = pix;
            if (i >= 1 && j >= 1) outs.push_back(make_result(i - 1, j - 1, 0, 0));
            if (i >= 1 && j == w - 1) outs.push_back(make_result(i - 1, w - 1, 0, 1));
            if (i == h - 1 && j >= 1) outs.push_back(make_result(i, j - 1, 1, 0));
            if (i == h - 1 && j == w - 1) outs.push_back(make_result(i, w - 1, 1, 1));
            if (outs.size() > 0) outs[outs.size() - 1].last_of_run = 1'b1;
            foreach (outs[k]) pending_q.push_back(outs[k]);
            j++;
            if (j >= w) begin
                j = 0;
                i++;
                if (i >= h) i = 0;
            end
            row_pos = i & 16'hFFFF;
            col_pos = j;
        endfunction

        task check_result(sobel_pkg::t_result got);
            sobel_pkg::t_result want;
            results_seen++;
            if (pending_q.size() == 0) begin
                report("unexpected result, out_row", int'(got.out_row), -1);
                return;
            end
            want = pending_q.pop_front();
            if (got.out_row != want.out_row) report("out_row", got.out_row, want.out_row);
            if (got.out_col != want.out_col) report("out_col", got.out_col, want.out_col);
            if (got.edge_red != want.edge_red) report("edge_red", got.edge_red, want.edge_red);
            if (got.edge_green != want.edge_green)
                report("edge_green", got.edge_green, want.edge_green);
            if (got.edge_blue != want.edge_blue)
                report("edge_blue", got.edge_blue, want.edge_blue);
            if (got.last_of_run != want.last_of_run)
                report("last_of_run", got.last_of_run, want.last_of_run);
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = sobel_pkg::CFG_FRAME_WIDTH;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    sobel_pkg::t_pixel_in i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    sobel_pkg::t_result   o_out_data;

    edge_scoreboard sb = new();
    int idle_cycles = 0;
    int burst_left = 0;
    int stall_left = 0;
    int ready_mode = 0;
    int cycle_cnt = 0;
    int frames_run = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    sobel_edge_magnitude_rgb dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // monitor both channels and the register port
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.write_reg(i_cfg_idx, i_cfg_data);
            if (i_in_valid && o_in_ready) sb.note_pixel(i_in_data);
            if (o_out_valid && i_out_ready) sb.check_result(o_out_data);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // receiver back-pressure; the ready pattern is drawn at random from four modes
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt % 128 == 0) ready_mode <= $urandom_range(0, 3);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            case (ready_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                2: i_out_ready <= ($urandom_range(0, 7) != 0);
                default: begin
                    i_out_ready <= 1'b0;
                    stall_left <= $urandom_range(0, 20);
                end
            endcase
        end
    end

    task write_reg(logic idx, logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task set_frame(logic [15:0] w, logic [15:0] h);
        write_reg(sobel_pkg::CFG_FRAME_WIDTH, w);
        write_reg(sobel_pkg::CFG_FRAME_HEIGHT, h);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        frames_run++;
    endtask

    task wait_drained();
        i_in_valid <= 1'b0;
        // let the monitor take the last transaction first
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function logic [7:0] pick_channel();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // hold valid and payload until the transaction completes
    task send_pixel(sobel_pkg::t_pixel_in p);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    task send_random(int n);
        sobel_pkg::t_pixel_in p;
        for (int k = 0; k < n; k++) begin
            p.red   = pick_channel();
            p.green = pick_channel();
            p.blue  = pick_channel();
            send_pixel(p);
        end
    endtask

    initial begin
        sobel_pkg::t_pixel_in p;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // a few pixels under the reset geometry
        send_random(8);
        wait_drained();

        // directed: 3x3 frame of extremes, then a full-white frame
        set_frame(16'd3, 16'd3);
        for (int k = 0; k < 9; k++) begin
            p = (k % 2) ? '1 : '0;
            send_pixel(p);
        end
        for (int k = 0; k < 9; k++) send_pixel('1);
        wait_drained();

        set_frame(16'd1, 16'd1);
        send_random(5);
        wait_drained();
        set_frame(16'd0, 16'd0);        // zero width and height act as one
        send_random(4);
        wait_drained();

        set_frame(16'd2, 16'd5);
        send_random(20);
        wait_drained();
        set_frame(16'd5, 16'd4);
        send_random(30);
        wait_drained();         // pause the sender mid-stream until drained
        send_random(30);
        wait_drained();
        set_frame(16'd7, 16'hFFFF);
        send_random(50);
        wait_drained();
        set_frame(16'd6, 16'd6);
        send_random(70);
        wait_drained();
        set_frame(16'd16, 16'd2);
        send_random(70);
        wait_drained();
        set_frame(16'd3, 16'd2);
        send_random(40);
        wait_drained();

        // width above the line depth clamps to 1024
        set_frame(16'hFFFF, 16'd1);
        send_random(40);
        wait_drained();

        $display("covered %0d frame setups, %0d pixels in, %0d results checked",
                 frames_run, sb.pixels_seen, sb.results_seen);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
